@@ design/pattern_match_line_column_core_macros.svh @@
// Assertion macros used by the pattern search output buffer.
`ifndef PATTERN_MATCH_LINE_COLUMN_CORE_MACROS_SVH
`define PATTERN_MATCH_LINE_COLUMN_CORE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define PMLC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define PMLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/pmlc_pkg.sv @@
// Package with the types and constants of the pattern search core.
`default_nettype none

package pmlc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned OUT_W      = 24;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PATTERN_BYTES  = 1'b0;
  localparam cfg_idx_t CFG_PATTERN_LENGTH = 1'b1;

  typedef struct packed {
    logic              shift_en;
    logic              active;
    logic [BYTE_W-1:0] want;
  } cell_ctrl_t;

  typedef struct packed {
    logic [OUT_W-1:0] occurrence_number;
    logic [OUT_W-1:0] start_line;
    logic [OUT_W-1:0] start_column;
  } result_t;

  typedef struct packed {
    logic push;
    logic pending;
  } buf_ctrl_t;

endpackage

`default_nettype wire

@@ design/pmlc_in_if.sv @@
// Stream interface that carries text bytes into the core.
`default_nettype none

interface pmlc_in_if;
  import pmlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

@@ design/pmlc_out_if.sv @@
// Stream interface that carries match results out of the core.
`default_nettype none

interface pmlc_out_if;
  import pmlc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] occurrence_number;
  logic [OUT_W-1:0] start_line;
  logic [OUT_W-1:0] start_column;

  modport source (output valid, output occurrence_number, output start_line,
                  output start_column, input ready);
  modport sink (input valid, input occurrence_number, input start_line,
                input start_column, output ready);
endinterface

`default_nettype wire

@@ design/pattern_match_line_column_core.sv @@
// Top level of the fixed-string search core with line and column tracking.
// The input channel in_ch takes one text byte per transfer; the result channel out_ch
// gives one result for each completed occurrence of the pattern: the running occurrence
// number and the line and column of the occurrence's first byte.
// The pattern is written through the cfg_ port: index 0 holds up to eight pattern bytes,
// first byte lowest, and index 1 holds the pattern length.
// The user writes the configuration only while no transfer is in progress; unenforced.
// A byte is taken in every cycle in which in_ch.ready is high; the history is a chain of
// cells that shifts once per transfer, and all cells compare in the following cycle.
// The cells register the completing byte; its result is then registered for out_ch.
// Reset clears the history, sets the line and column to one, the occurrence count to zero,
// the pattern to all zero bytes and the length to one.
// Results wait in a head register and a skid register; while both are held, or the head is
// stalled with a compare still due, in_ch.ready is low.
// Line, column and occurrence counters saturate at their maximum.
`default_nettype none

module pattern_match_line_column_core #(
  parameter int unsigned MAX_PATTERN  = 8,
  parameter int unsigned COUNTER_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire pmlc_pkg::cfg_idx_t                cfg_index,
  input  wire logic [pmlc_pkg::CFG_DATA_W-1:0]   cfg_data,
  pmlc_in_if.sink                                in_ch,
  pmlc_out_if.source                             out_ch
);
  import pmlc_pkg::*;

  localparam int unsigned IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned WIDE_W = (COUNTER_BITS > OUT_W) ? COUNTER_BITS : OUT_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
  localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);

  logic [CFG_DATA_W-1:0]   pattern_r;
  logic [LEN_W-1:0]        len_r;
  logic [LEN_W-1:0]        len_m1;
  logic [COUNTER_BITS-1:0] line_r;
  logic [COUNTER_BITS-1:0] line_nxt;
  logic [COUNTER_BITS-1:0] col_r;
  logic [COUNTER_BITS-1:0] col_nxt;
  logic [COUNTER_BITS-1:0] count_r;
  logic [COUNTER_BITS-1:0] count_nxt;
  logic                    eval_r;
  logic                    in_xfer;
  logic                    hit;
  logic                    space_ok;

  logic [BYTE_W-1:0]       q_byte [MAX_PATTERN];
  logic                    q_valid [MAX_PATTERN];
  logic [COUNTER_BITS-1:0] q_line [MAX_PATTERN];
  logic [COUNTER_BITS-1:0] q_col [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]  cell_ok;

  logic [WIDE_W-1:0] occ_wide;
  logic [WIDE_W-1:0] line_wide;
  logic [WIDE_W-1:0] col_wide;
  result_t           result;
  buf_ctrl_t         buf_ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= LEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:  pattern_r <= cfg_data;
        CFG_PATTERN_LENGTH: len_r     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      len_m1 = '0;
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_m1 = LEN_W'(MAX_PATTERN - 1);
    end else begin
      len_m1 = len_r - LEN_W'(1);
    end
  end

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = space_ok;

  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (in_xfer) begin
      if (in_ch.text_byte == NEWLINE_BYTE) begin
        line_nxt = (line_r == CNT_MAX) ? line_r : line_r + CNT_ONE;
        col_nxt  = CNT_ONE;
      end else begin
        col_nxt = (col_r == CNT_MAX) ? col_r : col_r + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= CNT_ONE;
      col_r   <= CNT_ONE;
      count_r <= '0;
      eval_r  <= 1'b0;
    end else begin
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      count_r <= hit ? count_nxt : count_r;
      eval_r  <= in_xfer;
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [LEN_W-1:0] diff;
    cell_ctrl_t       ctrl;

    assign diff          = len_m1 - LEN_W'(i);
    assign ctrl.shift_en = in_xfer;
    assign ctrl.active   = (LEN_W'(i) <= len_m1);
    assign ctrl.want     = pattern_r[{diff[2:0], 3'b000} +: BYTE_W];

    if (i == 0) begin : g_head
      pmlc_cell #(.COUNTER_BITS(COUNTER_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .d_byte  (in_ch.text_byte),
        .d_valid (1'b1),
        .d_line  (line_r),
        .d_col   (col_r),
        .q_byte  (q_byte[i]),
        .q_valid (q_valid[i]),
        .q_line  (q_line[i]),
        .q_col   (q_col[i]),
        .ok      (cell_ok[i])
      );
    end else begin : g_body
      pmlc_cell #(.COUNTER_BITS(COUNTER_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .d_byte  (q_byte[i-1]),
        .d_valid (q_valid[i-1]),
        .d_line  (q_line[i-1]),
        .d_col   (q_col[i-1]),
        .q_byte  (q_byte[i]),
        .q_valid (q_valid[i]),
        .q_line  (q_line[i]),
        .q_col   (q_col[i]),
        .ok      (cell_ok[i])
      );
    end
  end

  assign hit       = eval_r && (&cell_ok);
  assign count_nxt = (count_r == CNT_MAX) ? count_r : count_r + CNT_ONE;

  assign occ_wide  = WIDE_W'(count_nxt);
  assign line_wide = WIDE_W'(q_line[len_m1[IDX_W-1:0]]);
  assign col_wide  = WIDE_W'(q_col[len_m1[IDX_W-1:0]]);

  assign result.occurrence_number = occ_wide[OUT_W-1:0];
  assign result.start_line        = line_wide[OUT_W-1:0];
  assign result.start_column      = col_wide[OUT_W-1:0];

  assign buf_ctrl.push    = hit;
  assign buf_ctrl.pending = eval_r;

  pmlc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (buf_ctrl),
    .push_data (result),
    .space_ok  (space_ok),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

@@ design/pmlc_cell.sv @@
// One history cell: holds a byte with its position and compares it with a pattern byte.
`default_nettype none

module pmlc_cell #(
  parameter int unsigned COUNTER_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pmlc_pkg::cell_ctrl_t      ctrl,
  input  wire logic [7:0]                d_byte,
  input  wire logic                      d_valid,
  input  wire logic [COUNTER_BITS-1:0]   d_line,
  input  wire logic [COUNTER_BITS-1:0]   d_col,
  output logic [7:0]                     q_byte,
  output logic                           q_valid,
  output logic [COUNTER_BITS-1:0]        q_line,
  output logic [COUNTER_BITS-1:0]        q_col,
  output logic                           ok
);
  import pmlc_pkg::*;

  logic [BYTE_W-1:0]       byte_r;
  logic                    valid_r;
  logic [COUNTER_BITS-1:0] line_r;
  logic [COUNTER_BITS-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift_en) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      byte_r <= d_byte;
      line_r <= d_line;
      col_r  <= d_col;
    end
  end

  assign q_byte  = byte_r;
  assign q_valid = valid_r;
  assign q_line  = line_r;
  assign q_col   = col_r;
  assign ok      = !ctrl.active || (valid_r && (byte_r == ctrl.want));

endmodule

`default_nettype wire

@@ design/pmlc_out_buf.sv @@
// Two-entry result buffer: a head register that drives the result channel, with a skid register behind it.
`default_nettype none

`include "pattern_match_line_column_core_macros.svh"

module pmlc_out_buf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pmlc_pkg::buf_ctrl_t   ctrl,
  input  wire pmlc_pkg::result_t     push_data,
  output logic                       space_ok,
  pmlc_out_if.source                 out_ch
);
  import pmlc_pkg::*;

  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  result_t out_data_r;
  result_t out_data_nxt;
  result_t skid_data_r;
  result_t skid_data_nxt;
  logic    pop;
  logic    head_busy;

  assign pop = out_valid_r && out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    head_busy = out_valid_nxt;
    if (ctrl.push) begin
      if (!head_busy) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space_ok = !skid_valid_r && !(ctrl.pending && out_valid_r && !out_ch.ready);

  assign out_ch.valid             = out_valid_r;
  assign out_ch.occurrence_number = out_data_r.occurrence_number;
  assign out_ch.start_line        = out_data_r.start_line;
  assign out_ch.start_column      = out_data_r.start_column;

  `PMLC_ASSERT(a_skid_behind_head, !skid_valid_r || out_valid_r, "Skid entry held without a head entry.")
  `PMLC_ASSERT(a_no_overflow, !(ctrl.push && skid_valid_r), "Result pushed while both entries are full.")
  `PMLC_ASSERT_NEXT(a_drain, pop && !skid_valid_r && !ctrl.push, !out_valid_r, "Buffer failed to empty after the last transfer.")

endmodule

`default_nettype wire
